// ----- rtl/core/alte_pkg.sv -----
// ----------------------------------------------------------------------------
// Array list table engine package
// Sizes, operation codes, status codes and controller states.
// ----------------------------------------------------------------------------
package alte_pkg;

	localparam int CAPACITY    = 64;
	localparam int ENTRY_WIDTH = 64;

	// Fixed field widths of the transaction payload
	localparam int FUNC_W  = 3;
	localparam int POS_W   = 7;
	localparam int VALUE_W = 64;

	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT   = 3'd0,
		FUNC_DELETE   = 3'd1,
		FUNC_LOCATE   = 3'd2,
		FUNC_RETRIEVE = 3'd3,
		FUNC_NEXT     = 3'd4,
		FUNC_PREVIOUS = 3'd5,
		FUNC_FIRST    = 3'd6,
		FUNC_CLEAR    = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_UNDEF = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP,
		ST_PUT,
		ST_DOWN,
		ST_SCAN,
		ST_READ,
		ST_RESP
	} state_t;

endpackage

// ----- rtl/core/alte_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module alte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/array_list_table_engine.sv -----
// ----------------------------------------------------------------------------
// Array list table engine
// Ordered list of up to CAPACITY entries held in one RAM, one operation at a time.
// ----------------------------------------------------------------------------
// Next, previous, first, clear and errors go straight to the response; retrieve
// reads the entry; locate compares entries from 0 until a match or the end; insert
// at p moves entries count-1 down to p up by one, then writes the value; delete at
// p moves entries above p down by one; one RAM access per entry moved or compared.
// One operation is in flight at a time; a new one is taken while the result waits.
// Reset clears the count and the handshake state; the RAM is not cleared.
module array_list_table_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [alte_pkg::FUNC_W-1:0]  func,
	input  logic [alte_pkg::POS_W-1:0]   position,
	input  logic [alte_pkg::VALUE_W-1:0] entry_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [alte_pkg::POS_W-1:0]   result_position,
	output logic [alte_pkg::VALUE_W-1:0] result_value,
	output logic [alte_pkg::POS_W-1:0]   entry_count
);
	import alte_pkg::*;

	state_t                  state_q, state_d;
	logic [CNT_W-1:0]        cnt_q, cnt_d;
	logic [ADDR_W-1:0]       rd_q, rd_d;
	logic [POS_W-1:0]        pos_q, pos_d;
	logic [ENTRY_WIDTH-1:0]  val_q, val_d;

	status_t                 res_status_q, res_status_d;
	logic [POS_W-1:0]        res_pos_q, res_pos_d;
	logic [VALUE_W-1:0]      res_val_q, res_val_d;
	logic [POS_W-1:0]        res_cnt_q, res_cnt_d;

	logic                    out_valid_q, out_valid_d;
	status_t                 status_q, status_d;
	logic [POS_W-1:0]        rpos_q, rpos_d;
	logic [VALUE_W-1:0]      rval_q, rval_d;
	logic [POS_W-1:0]        ecnt_q, ecnt_d;

	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	logic [ENTRY_WIDTH-1:0]  ram_wdata;
	logic [ENTRY_WIDTH-1:0]  ram_rdata;

	logic [CMP_W-1:0]        pos_cmp;
	logic [CMP_W-1:0]        cnt_cmp;

	alte_ram #(
		.WIDTH (ENTRY_WIDTH),
		.DEPTH (CAPACITY)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_d),
		.rdata (ram_rdata)
	);

	assign pos_cmp = CMP_W'(position);
	assign cnt_cmp = CMP_W'(cnt_q);

	assign in_ready        = (state_q == ST_IDLE);
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign result_position = rpos_q;
	assign result_value    = rval_q;
	assign entry_count     = ecnt_q;

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		rd_d         = rd_q;
		pos_d        = pos_q;
		val_d        = val_q;
		res_status_d = res_status_q;
		res_pos_d    = res_pos_q;
		res_val_d    = res_val_q;
		res_cnt_d    = res_cnt_q;
		out_valid_d  = out_valid_q;
		status_d     = status_q;
		rpos_d       = rpos_q;
		rval_d       = rval_q;
		ecnt_d       = ecnt_q;
		ram_we       = 1'b0;
		ram_waddr    = rd_q;
		ram_wdata    = ram_rdata;

		// drop the result once taken
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					pos_d        = position;
					val_d        = entry_value[ENTRY_WIDTH-1:0];
					res_status_d = STATUS_OK;
					res_pos_d    = POS_W'(cnt_q);
					res_val_d    = '0;
					res_cnt_d    = POS_W'(cnt_q);
					state_d      = ST_RESP;
					case (func_t'(func))
						FUNC_INSERT: begin
							if (pos_cmp > cnt_cmp) begin
								res_status_d = STATUS_UNDEF;
							end else if (cnt_q == CNT_W'(CAPACITY)) begin
								res_status_d = STATUS_FULL;
							end else begin
								cnt_d     = cnt_q + CNT_W'(1);
								res_cnt_d = POS_W'(cnt_q + CNT_W'(1));
								res_pos_d = position;
								if (pos_cmp == cnt_cmp) begin
									state_d = ST_PUT;
								end else begin
									// start the shift at the old last entry
									rd_d    = ADDR_W'(cnt_q - CNT_W'(1));
									state_d = ST_UP;
								end
							end
						end
						FUNC_DELETE: begin
							if (pos_cmp >= cnt_cmp) begin
								res_status_d = STATUS_UNDEF;
							end else begin
								cnt_d     = cnt_q - CNT_W'(1);
								res_cnt_d = POS_W'(cnt_q - CNT_W'(1));
								res_pos_d = POS_W'(cnt_q - CNT_W'(1));
								if (pos_cmp + CMP_W'(1) != cnt_cmp) begin
									rd_d    = ADDR_W'(pos_cmp + CMP_W'(1));
									state_d = ST_DOWN;
								end
							end
						end
						FUNC_LOCATE: begin
							if (cnt_q != '0) begin
								rd_d    = '0;
								state_d = ST_SCAN;
							end
						end
						FUNC_RETRIEVE: begin
							if (pos_cmp >= cnt_cmp) begin
								res_status_d = STATUS_UNDEF;
							end else begin
								rd_d    = ADDR_W'(position);
								state_d = ST_READ;
							end
						end
						FUNC_NEXT: begin
							if (pos_cmp >= cnt_cmp) begin
								res_status_d = STATUS_UNDEF;
							end else begin
								res_pos_d = position + POS_W'(1);
							end
						end
						FUNC_PREVIOUS: begin
							if (position == '0 || pos_cmp > cnt_cmp) begin
								res_status_d = STATUS_UNDEF;
							end else begin
								res_pos_d = position - POS_W'(1);
							end
						end
						FUNC_FIRST: begin
							res_pos_d = '0;
						end
						FUNC_CLEAR: begin
							cnt_d     = '0;
							res_pos_d = '0;
							res_cnt_d = '0;
						end
						default: begin
							res_status_d = STATUS_UNDEF;
						end
					endcase
				end
			end
			ST_UP: begin
				// move entry rd up by one, read the one below
				ram_we    = 1'b1;
				ram_waddr = rd_q + ADDR_W'(1);
				if (rd_q == ADDR_W'(pos_q)) begin
					state_d = ST_PUT;
				end else begin
					rd_d = rd_q - ADDR_W'(1);
				end
			end
			ST_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = ADDR_W'(pos_q);
				ram_wdata = val_q;
				state_d   = ST_RESP;
			end
			ST_DOWN: begin
				// move entry rd down by one; cnt already holds the new count
				ram_we    = 1'b1;
				ram_waddr = rd_q - ADDR_W'(1);
				if (CNT_W'(rd_q) == cnt_q) begin
					state_d = ST_RESP;
				end else begin
					rd_d = rd_q + ADDR_W'(1);
				end
			end
			ST_SCAN: begin
				if (ram_rdata == val_q) begin
					res_pos_d = POS_W'(rd_q);
					state_d   = ST_RESP;
				end else if (CNT_W'(rd_q) + CNT_W'(1) == cnt_q) begin
					state_d = ST_RESP;
				end else begin
					rd_d = rd_q + ADDR_W'(1);
				end
			end
			ST_READ: begin
				res_val_d = VALUE_W'(ram_rdata);
				state_d   = ST_RESP;
			end
			ST_RESP: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					out_valid_d = 1'b1;
					status_d    = res_status_q;
					rpos_d      = res_pos_q;
					rval_d      = res_val_q;
					ecnt_d      = res_cnt_q;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_q         <= rd_d;
		pos_q        <= pos_d;
		val_q        <= val_d;
		res_status_q <= res_status_d;
		res_pos_q    <= res_pos_d;
		res_val_q    <= res_val_d;
		res_cnt_q    <= res_cnt_d;
		status_q     <= status_d;
		rpos_q       <= rpos_d;
		rval_q       <= rval_d;
		ecnt_q       <= ecnt_d;
	end

endmodule
